/* rtl/mtg_pkg.sv */
// ----------------------------------------------------------------------------
// mtg_pkg
// Types, constants and word functions shared by the twister generator files.
// ----------------------------------------------------------------------------
package mtg_pkg;

	localparam int WORD_W        = 32;
	localparam int TABLE_WORDS   = 624;
	localparam int MIDDLE_OFFSET = 397;
	localparam int IDX_W         = $clog2(TABLE_WORDS);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  tbl_idx_t;

	localparam word_t SEED_DEFAULT    = 32'd5489;
	localparam word_t SEED_MULTIPLIER = 32'd1812433253;
	localparam word_t TWIST_MATRIX    = 32'h9908_b0df;
	localparam word_t TEMPER_MASK_B   = 32'h9d2c_5680;
	localparam word_t TEMPER_MASK_C   = 32'hefc6_0000;

	localparam tbl_idx_t TBL_LAST  = tbl_idx_t'(TABLE_WORDS - 1);
	localparam tbl_idx_t MID_SPLIT = tbl_idx_t'(TABLE_WORDS - MIDDLE_OFFSET);
	localparam tbl_idx_t MID_UP    = tbl_idx_t'(MIDDLE_OFFSET);
	localparam tbl_idx_t MID_DOWN  = tbl_idx_t'(TABLE_WORDS - MIDDLE_OFFSET);

	// output tempering
	function automatic word_t temper(input word_t w_in);
		word_t w;
		w = w_in;
		w = w ^ (w >> 11);
		w = w ^ ((w << 7) & TEMPER_MASK_B);
		w = w ^ ((w << 15) & TEMPER_MASK_C);
		w = w ^ (w >> 18);
		return w;
	endfunction

	// one twist step: high bit of the current word, low bits of the next one
	function automatic word_t twist(input word_t cur, input word_t nxt, input word_t mid);
		word_t joined;
		word_t mixed;
		joined = {cur[WORD_W-1], nxt[WORD_W-2:0]};
		mixed  = mid ^ (joined >> 1);
		if (joined[0]) begin
			mixed = mixed ^ TWIST_MATRIX;
		end
		return mixed;
	endfunction

endpackage

/* rtl/mtg_if.sv */
// ----------------------------------------------------------------------------
// mtg_if
// Valid/ready channels of the twister generator: draw requests and words.
// ----------------------------------------------------------------------------
interface mtg_req_if;
	logic valid;
	logic ready;
	logic draw_request;

	modport source (output valid, output draw_request, input ready);
	modport sink   (input valid, input draw_request, output ready);
endinterface

interface mtg_word_if;
	logic          valid;
	logic          ready;
	mtg_pkg::word_t random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface

/* rtl/mersenne_twister_generator.sv */
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// 32-bit MT19937 generator, state table in a 624-word two-read memory.
// ----------------------------------------------------------------------------
// draw path: an accepted item loads the two read registers; in ST_CALC the tempered twist
// enters the output register once it can take it; one item is in work at a time
// reset: async, then a seeding pass with ready low (ST_SEED_MUL, ST_SEED_ADD per word)
// a seed write starts the same seeding pass; the first draw after it twists word 0
// ----------------------------------------------------------------------------
module mersenne_twister_generator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              seed_we,
	input  mtg_pkg::word_t    seed_wdata,
	mtg_req_if.sink           req,
	mtg_word_if.source        word
);
	import mtg_pkg::*;

	// controller states
	localparam logic [2:0] ST_SEED0    = 3'd0;
	localparam logic [2:0] ST_SEED_MUL = 3'd1;
	localparam logic [2:0] ST_SEED_ADD = 3'd2;
	localparam logic [2:0] ST_IDLE     = 3'd3;
	localparam logic [2:0] ST_CALC     = 3'd4;

	logic [2:0] state_q;

	// seed register and seeding chain
	word_t    seed_q;
	word_t    prev_q;     // last word written while seeding
	word_t    prod_q;     // registered multiplier output
	tbl_idx_t sidx_q;     // table entry being seeded

	// draw side
	tbl_idx_t idx_q;      // next entry to twist and hand out
	word_t    cur_q;      // current value of table[idx_q], kept out of memory

	// state table: one write port, two registered read ports
	word_t    table_mem [TABLE_WORDS];
	word_t    rd_next_s1;
	word_t    rd_mid_s1;
	logic     rd_en;
	tbl_idx_t rd_next_addr;
	tbl_idx_t rd_mid_addr;
	logic     wr_en;
	tbl_idx_t wr_addr;
	word_t    wr_data;

	// output register
	logic  word_valid_q;
	word_t word_data_q;

	logic     draw_fire;
	logic     calc_fire;
	word_t    seed_word;
	word_t    twisted;
	tbl_idx_t idx_inc;

	assign req.ready        = (state_q == ST_IDLE);
	assign word.valid       = word_valid_q;
	assign word.random_word = word_data_q;

	assign draw_fire = req.valid && req.ready && req.draw_request;
	// twist result moves on only when the output register can take it
	assign calc_fire = (state_q == ST_CALC) && (!word_valid_q || word.ready);

	assign idx_inc   = (idx_q == TBL_LAST) ? '0 : idx_q + tbl_idx_t'(1);
	// seeding step: product of the previous cycle plus the entry number
	assign seed_word = prod_q + {{(WORD_W-IDX_W){1'b0}}, sidx_q};
	// neighbors: below idx_q the table already holds the new generation,
	// which is exactly what the in-order twist of the whole table would see
	assign twisted   = twist(cur_q, rd_next_s1, rd_mid_s1);

	// read addresses for the entry after idx_q and its middle partner
	always_comb begin
		rd_en        = draw_fire;
		rd_next_addr = idx_inc;
		if (idx_q < MID_SPLIT) begin
			rd_mid_addr = idx_q + MID_UP;
		end else begin
			rd_mid_addr = idx_q - MID_DOWN;
		end
	end

	// write port shared by seeding and twisting
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = twisted;
		case (state_q)
			ST_SEED0: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = seed_q;
			end
			ST_SEED_ADD: begin
				wr_en   = 1'b1;
				wr_addr = sidx_q;
				wr_data = seed_word;
			end
			ST_CALC: begin
				wr_en = calc_fire;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_next_s1 <= table_mem[rd_next_addr];
			rd_mid_s1  <= table_mem[rd_mid_addr];
		end
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SEED0;
			seed_q  <= SEED_DEFAULT;
			idx_q   <= '0;
			sidx_q  <= '0;
		end else begin
			case (state_q)
				ST_SEED0: begin
					sidx_q  <= tbl_idx_t'(1);
					state_q <= ST_SEED_MUL;
				end
				ST_SEED_MUL: begin
					state_q <= ST_SEED_ADD;
				end
				ST_SEED_ADD: begin
					if (sidx_q == TBL_LAST) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						sidx_q  <= sidx_q + tbl_idx_t'(1);
						state_q <= ST_SEED_MUL;
					end
				end
				ST_IDLE: begin
					// an item with no request is taken and dropped
					if (draw_fire) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (calc_fire) begin
						idx_q   <= idx_inc;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_SEED0;
				end
			endcase
			// reseed on a seed write, which the user must only issue while idle; the block does not enforce it
			if (seed_we) begin
				seed_q  <= seed_wdata;
				state_q <= ST_SEED0;
			end
		end
	end

	// seeding datapath and the cached current word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SEED0: begin
				prev_q <= seed_q;
				cur_q  <= seed_q;
			end
			ST_SEED_MUL: begin
				prod_q <= SEED_MULTIPLIER * (prev_q ^ (prev_q >> 30));
			end
			ST_SEED_ADD: begin
				prev_q <= seed_word;
			end
			ST_CALC: begin
				// entry idx_q+1 is not written again before its own twist
				if (calc_fire) begin
					cur_q <= rd_next_s1;
				end
			end
			default: begin
				prev_q <= prev_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
		end else if (calc_fire) begin
			word_valid_q <= 1'b1;
		end else if (word.ready) begin
			word_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (calc_fire) begin
			word_data_q <= temper(twisted);
		end
	end

endmodule

/* rtl/mtg_checker.sv */
// ----------------------------------------------------------------------------
// mtg_checker
// Port-level checks of the twister generator, bound to the generator module.
// ----------------------------------------------------------------------------
module mtg_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           seed_we,
	input logic           req_valid,
	input logic           req_ready,
	input logic           req_draw,
	input logic           word_valid,
	input logic           word_ready,
	input mtg_pkg::word_t word_data
);
	import mtg_pkg::*;

	// a stalled word holds
	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_ready |=> word_valid && $stable(word_data))
		else $error("stalled word changed or dropped");

	// one draw at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_draw |=> !req_ready)
		else $error("item accepted while another is in work");

	// a fresh word follows an accepted draw request
	a_word_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(word_valid) |-> $past(req_valid && req_ready && req_draw, 2))
		else $error("word shown without a matching draw");

	// a seed write starts reseeding and blocks draws
	a_seed_block: assert property (@(posedge clk) disable iff (!arst_n)
		seed_we |=> !req_ready)
		else $error("draw accepted right after seed write");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.seed_we    (seed_we),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_draw   (req.draw_request),
	.word_valid (word.valid),
	.word_ready (word.ready),
	.word_data  (word.random_word)
);
